>>> rtl/core/mesh_dihedral_feature_edge_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef MESH_DIHEDRAL_FEATURE_EDGE_CORE_MACROS_SVH
`define MESH_DIHEDRAL_FEATURE_EDGE_CORE_MACROS_SVH

// Property checked at every rising edge outside reset.
`define MDFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mdfe assertion failed");

// Same-cycle implication.
`define MDFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `MDFE_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define MDFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    `MDFE_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/core/mdfe_pkg.sv
package mdfe_pkg;

    localparam int VTX_W     = 60;
    localparam int ANG_W     = 18;
    localparam int THR_W     = 7;
    localparam int NORM_BITS = 15;
    localparam int NORM_W    = NORM_BITS + 1;
    localparam int PROD_W    = 32;
    localparam int CROSS_W   = 33;
    localparam int DOT_W     = 34;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int CX_W      = 36;
    localparam int Z_W       = 34;
    localparam int Z_FRAC    = 30;
    localparam int NORM_LAT  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [Z_W-1:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [24:0]    DEG_Q30     = 25'd18740331;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_BND   = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0] tri1_vertex_a;
        logic [VTX_W-1:0] tri1_vertex_b;
        logic [VTX_W-1:0] tri1_vertex_c;
        logic [VTX_W-1:0] tri2_vertex_a;
        logic [VTX_W-1:0] tri2_vertex_b;
        logic [VTX_W-1:0] tri2_vertex_c;
        logic             has_second_face;
    } t_in_item;

    typedef struct packed {
        logic [ANG_W-1:0] angle_rad;
        logic             is_feature;
        logic             degenerate;
    } t_out_item;

    // Per-item control that travels beside the datapath.
    typedef struct packed {
        logic vld;
        logic bnd;
        logic dgn;
    } t_side;

    // atan(2^-i) in units of 2^-30 rad.
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/mdfe_normal.sv
module mdfe_normal #(
    parameter int COORD_BITS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic        [mdfe_pkg::VTX_W-1:0]  i_pa,
    input  logic        [mdfe_pkg::VTX_W-1:0]  i_pb,
    input  logic        [mdfe_pkg::VTX_W-1:0]  i_pc,
    output logic signed [mdfe_pkg::NORM_W-1:0] o_nrm [3],
    output logic                               o_zero
);
    import mdfe_pkg::*;

    localparam int DIF_W = COORD_BITS + 1;
    localparam int MUL_W = 2 * DIF_W;
    localparam int NRM_W = MUL_W + 1;
    localparam int MAG_W = 2 * COORD_BITS + 1;
    localparam int NGRP  = (MAG_W + 7) / 8;
    localparam int PAD_W = NGRP * 8;
    localparam int LEN_W = $clog2(MAG_W + 1);
    localparam int EXT_W = VTX_W + 3 * COORD_BITS;

    // Vertices are zero-extended so that every coordinate slice lies inside the vector.
    logic [EXT_W-1:0]             w_xa;
    logic [EXT_W-1:0]             w_xb;
    logic [EXT_W-1:0]             w_xc;
    logic signed [COORD_BITS-1:0] w_ca [3];
    logic signed [COORD_BITS-1:0] w_cb [3];
    logic signed [COORD_BITS-1:0] w_cc [3];

    logic signed [DIF_W-1:0] r_a [3];
    logic signed [DIF_W-1:0] r_b [3];
    logic signed [MUL_W-1:0] r_p [6];
    logic signed [NRM_W-1:0] r_n [3];
    logic [MAG_W-1:0]        r_mag4 [3];
    logic [2:0]              r_neg4;
    logic [MAG_W-1:0]        r_or;
    logic [MAG_W-1:0]        r_mag5 [3];
    logic [2:0]              r_neg5;
    logic [NGRP-1:0]         r_gnz;
    logic [2:0]              r_gpos [NGRP];
    logic [MAG_W-1:0]        r_mag6 [3];
    logic [2:0]              r_neg6;
    logic [LEN_W-1:0]        r_len;
    logic                    r_zero6;

    logic [NRM_W-1:0]        w_abs [3];
    logic [PAD_W-1:0]        w_pad;
    logic [NGRP-1:0]         w_gnz;
    logic [2:0]              w_gpos [NGRP];
    logic [LEN_W-1:0]        w_len;
    logic [MAG_W-1:0]        w_sh [3];
    logic signed [NORM_W-1:0] w_nrm [3];

    assign w_xa = EXT_W'(i_pa);
    assign w_xb = EXT_W'(i_pb);
    assign w_xc = EXT_W'(i_pc);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ca[k] = w_xa[k*COORD_BITS +: COORD_BITS];
            w_cb[k] = w_xb[k*COORD_BITS +: COORD_BITS];
            w_cc[k] = w_xc[k*COORD_BITS +: COORD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= DIF_W'(w_ca[k]) - DIF_W'(w_cb[k]);
                r_b[k] <= DIF_W'(w_ca[k]) - DIF_W'(w_cc[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= MUL_W'(r_a[1]) * MUL_W'(r_b[2]);
            r_p[1] <= MUL_W'(r_a[2]) * MUL_W'(r_b[1]);
            r_p[2] <= MUL_W'(r_a[2]) * MUL_W'(r_b[0]);
            r_p[3] <= MUL_W'(r_a[0]) * MUL_W'(r_b[2]);
            r_p[4] <= MUL_W'(r_a[0]) * MUL_W'(r_b[1]);
            r_p[5] <= MUL_W'(r_a[1]) * MUL_W'(r_b[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= NRM_W'(r_p[2*k]) - NRM_W'(r_p[2*k+1]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r_n[k][NRM_W-1] ? NRM_W'(-r_n[k]) : NRM_W'(r_n[k]);
        end
    end

    // The bit length of the largest magnitude equals that of the OR of all three.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mag4[k] <= w_abs[k][MAG_W-1:0];
                r_neg4[k] <= r_n[k][NRM_W-1];
            end
            r_or <= w_abs[0][MAG_W-1:0] | w_abs[1][MAG_W-1:0] | w_abs[2][MAG_W-1:0];
        end
    end

    always_comb begin
        w_pad = PAD_W'(r_or);
        for (int g = 0; g < NGRP; g++) begin
            w_gnz[g]  = |w_pad[g*8 +: 8];
            w_gpos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_pad[g*8+b]) begin
                    w_gpos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
            r_gnz  <= w_gnz;
            r_gpos <= w_gpos;
        end
    end

    always_comb begin
        w_len = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_gnz[g]) begin
                w_len = LEN_W'(g * 8) + LEN_W'(r_gpos[g]) + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag6  <= r_mag5;
            r_neg6  <= r_neg5;
            r_len   <= w_len;
            r_zero6 <= ~|r_gnz;
        end
    end

    // Common shift puts the largest magnitude in [2^14, 2^15); right shifts truncate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_len > LEN_W'(NORM_BITS)) begin
                w_sh[k] = r_mag6[k] >> (r_len - LEN_W'(NORM_BITS));
            end else begin
                w_sh[k] = r_mag6[k] << (LEN_W'(NORM_BITS) - r_len);
            end
            w_nrm[k] = r_neg6[k] ? -NORM_W'(w_sh[k][NORM_BITS-1:0])
                                 : NORM_W'(w_sh[k][NORM_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_nrm  <= w_nrm;
            o_zero <= r_zero6;
        end
    end

endmodule

>>> rtl/core/mdfe_sqrt_cell.sv
module mdfe_sqrt_cell #(
    parameter int BIT = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  mdfe_pkg::t_side                    i_side,
    input  logic        [mdfe_pkg::SQ_W-1:0]   i_rem,
    input  logic        [mdfe_pkg::ROOT_W-1:0] i_root,
    input  logic signed [mdfe_pkg::DOT_W-1:0]  i_dot,
    output mdfe_pkg::t_side                    o_side,
    output logic        [mdfe_pkg::SQ_W-1:0]   o_rem,
    output logic        [mdfe_pkg::ROOT_W-1:0] o_root,
    output logic signed [mdfe_pkg::DOT_W-1:0]  o_dot
);
    import mdfe_pkg::*;

    localparam int TR_W = SQ_W + 2;

    logic [TR_W-1:0] w_trial;
    logic            w_take;

    // Try setting this root bit: (2*root*2^BIT + 2^(2*BIT)) against the remainder.
    assign w_trial = (TR_W'(i_root) << (BIT + 1)) | (TR_W'(1) << (2 * BIT));
    assign w_take  = TR_W'(i_rem) >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dot  <= i_dot;
            o_rem  <= w_take ? (i_rem - w_trial[SQ_W-1:0]) : i_rem;
            o_root <= w_take ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
        end
    end

endmodule

>>> rtl/core/mdfe_cordic_cell.sv
module mdfe_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  mdfe_pkg::t_side                  i_side,
    input  logic signed [mdfe_pkg::CX_W-1:0] i_x,
    input  logic signed [mdfe_pkg::CX_W-1:0] i_y,
    input  logic signed [mdfe_pkg::Z_W-1:0]  i_z,
    output mdfe_pkg::t_side                  o_side,
    output logic signed [mdfe_pkg::CX_W-1:0] o_x,
    output logic signed [mdfe_pkg::CX_W-1:0] o_y,
    output logic signed [mdfe_pkg::Z_W-1:0]  o_z
);
    import mdfe_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_q30(STAGE));

    logic signed [CX_W-1:0] w_xs;
    logic signed [CX_W-1:0] w_ys;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    // Vectoring step: drive y toward zero and collect the turned angle in z.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + ANG;
            end else begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - ANG;
            end
        end
    end

endmodule

>>> rtl/core/mesh_dihedral_feature_edge_core.sv
// Dihedral-angle feature test, one mesh edge per transfer.
// Input channel (i_in_valid / o_in_ready, i_in_data): the two triangles of one edge and
// a flag for the second one. Output channel (o_out_valid / i_out_ready, o_out_data):
// the angle between the face normals, the feature flag and the degenerate flag.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// threshold in degrees, index 1 sets include-boundary. Write it only while idle.
// The datapath is a fixed pipeline: seven stages of normal forming and normalizing,
// four stages of cross, dot and square sums, one square-root cell per result bit (32),
// one pre-rotation stage, one CORDIC cell per stage and one output register.
// One edge enters per cycle unless the output stalls.
// All stages move together: while a result sits unaccepted in the output register,
// o_in_ready is low and the whole pipeline holds its contents.
// Reset (synchronous, active low) empties the pipeline and loads threshold 40 and
// include-boundary 0.
module mesh_dihedral_feature_edge_core #(
    parameter int COORD_BITS      = 20,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  mdfe_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output mdfe_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mdfe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mdfe_pkg::THR_W-1:0]           i_cfg_data
);
    import mdfe_pkg::*;

    logic             w_en;
    logic [THR_W-1:0] r_thr;
    logic             r_incb;

    assign w_en        = ~o_out_valid | i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_W'(40);
            r_incb <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr  <= i_cfg_data;
                CFG_INC_BND:   r_incb <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- normals ----------------
    logic signed [NORM_W-1:0] w_n1 [3];
    logic signed [NORM_W-1:0] w_n2 [3];
    logic                     w_z1;
    logic                     w_z2;
    t_side                    r_sd [NORM_LAT];
    t_side                    w_s0;

    assign w_s0 = '{vld: i_in_valid & w_en, bnd: ~i_in_data.has_second_face, dgn: 1'b0};

    mdfe_normal #(.COORD_BITS(COORD_BITS)) u_nrm1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_pa  (i_in_data.tri1_vertex_a),
        .i_pb  (i_in_data.tri1_vertex_b),
        .i_pc  (i_in_data.tri1_vertex_c),
        .o_nrm (w_n1),
        .o_zero(w_z1)
    );

    mdfe_normal #(.COORD_BITS(COORD_BITS)) u_nrm2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_pa  (i_in_data.tri2_vertex_a),
        .i_pb  (i_in_data.tri2_vertex_b),
        .i_pc  (i_in_data.tri2_vertex_c),
        .o_nrm (w_n2),
        .o_zero(w_z2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_LAT; k++) begin
                r_sd[k] <= '0;
            end
        end else if (w_en) begin
            r_sd[0] <= w_s0;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // ---------------- cross and dot of the normalized normals ----------------
    logic signed [PROD_W-1:0]  r_pc [6];
    logic signed [PROD_W-1:0]  r_pd [3];
    logic signed [CROSS_W-1:0] r_c [3];
    logic signed [DOT_W-1:0]   r_dot2;
    logic [SQ_W-1:0]           r_sqc [3];
    logic signed [DOT_W-1:0]   r_dot3;
    logic [SQ_W-1:0]           r_sq;
    logic signed [DOT_W-1:0]   r_dot4;
    t_side                     r_s1;
    t_side                     r_s2;
    t_side                     r_s3;
    t_side                     r_s4;
    logic [CROSS_W-1:0]        w_cabs [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (w_en) begin
            r_s1 <= '{vld: r_sd[NORM_LAT-1].vld,
                      bnd: r_sd[NORM_LAT-1].bnd,
                      dgn: ~r_sd[NORM_LAT-1].bnd & (w_z1 | w_z2)};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc[0] <= PROD_W'(w_n1[1]) * PROD_W'(w_n2[2]);
            r_pc[1] <= PROD_W'(w_n1[2]) * PROD_W'(w_n2[1]);
            r_pc[2] <= PROD_W'(w_n1[2]) * PROD_W'(w_n2[0]);
            r_pc[3] <= PROD_W'(w_n1[0]) * PROD_W'(w_n2[2]);
            r_pc[4] <= PROD_W'(w_n1[0]) * PROD_W'(w_n2[1]);
            r_pc[5] <= PROD_W'(w_n1[1]) * PROD_W'(w_n2[0]);
            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= PROD_W'(w_n1[k]) * PROD_W'(w_n2[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cabs[k] = r_c[k][CROSS_W-1] ? CROSS_W'(-r_c[k]) : CROSS_W'(r_c[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k]   <= CROSS_W'(r_pc[2*k]) - CROSS_W'(r_pc[2*k+1]);
                r_sqc[k] <= SQ_W'(w_cabs[k][ROOT_W-1:0]) * SQ_W'(w_cabs[k][ROOT_W-1:0]);
            end
            r_dot2 <= DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
            r_dot3 <= r_dot2;
            r_sq   <= r_sqc[0] + r_sqc[1] + r_sqc[2];
            r_dot4 <= r_dot3;
        end
    end

    // ---------------- square root, one result bit per cell ----------------
    t_side                   w_qs [ROOT_W+1];
    logic [SQ_W-1:0]         w_qrem [ROOT_W+1];
    logic [ROOT_W-1:0]       w_qroot [ROOT_W+1];
    logic signed [DOT_W-1:0] w_qdot [ROOT_W+1];

    assign w_qs[0]    = r_s4;
    assign w_qrem[0]  = r_sq;
    assign w_qroot[0] = '0;
    assign w_qdot[0]  = r_dot4;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        mdfe_sqrt_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_side (w_qs[g]),
            .i_rem  (w_qrem[g]),
            .i_root (w_qroot[g]),
            .i_dot  (w_qdot[g]),
            .o_side (w_qs[g+1]),
            .o_rem  (w_qrem[g+1]),
            .o_root (w_qroot[g+1]),
            .o_dot  (w_qdot[g+1])
        );
    end

    // ---------------- pre-rotation and CORDIC ----------------
    t_side                  w_cs [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  w_cz [CORDIC_STAGES+1];
    t_side                  r_s5;
    logic signed [CX_W-1:0] r_x5;
    logic signed [CX_W-1:0] r_y5;
    logic signed [Z_W-1:0]  r_z5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5 <= '0;
        end else if (w_en) begin
            r_s5 <= w_qs[ROOT_W];
        end
    end

    // A negative dot product is turned by a quarter turn first.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_qdot[ROOT_W] < 0) begin
                r_x5 <= CX_W'(w_qroot[ROOT_W]);
                r_y5 <= -CX_W'(w_qdot[ROOT_W]);
                r_z5 <= HALF_PI_Q30;
            end else begin
                r_x5 <= CX_W'(w_qdot[ROOT_W]);
                r_y5 <= CX_W'(w_qroot[ROOT_W]);
                r_z5 <= '0;
            end
        end
    end

    assign w_cs[0] = r_s5;
    assign w_cx[0] = r_x5;
    assign w_cy[0] = r_y5;
    assign w_cz[0] = r_z5;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        mdfe_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_side (w_cs[g]),
            .i_x    (w_cx[g]),
            .i_y    (w_cy[g]),
            .i_z    (w_cz[g]),
            .o_side (w_cs[g+1]),
            .o_x    (w_cx[g+1]),
            .o_y    (w_cy[g+1]),
            .o_z    (w_cz[g+1])
        );
    end

    // ---------------- rounding, threshold and output register ----------------
    t_side            w_fs;
    logic [Z_W-1:0]   w_zq;
    logic [Z_W-1:0]   w_rnd;
    logic [Z_W-1:0]   w_ang;
    logic [31:0]      w_thr_q30;
    t_out_item        w_res;

    assign w_fs      = w_cs[CORDIC_STAGES];
    assign w_zq      = w_cz[CORDIC_STAGES][Z_W-1] ? '0 : Z_W'(w_cz[CORDIC_STAGES]);
    assign w_rnd     = w_zq + (Z_W'(1) << (Z_FRAC - 1 - ANGLE_FRAC_BITS));
    assign w_ang     = w_rnd >> (Z_FRAC - ANGLE_FRAC_BITS);
    assign w_thr_q30 = 32'(r_thr) * 32'(DEG_Q30);

    always_comb begin
        if (w_fs.bnd) begin
            w_res = '{angle_rad: '0, is_feature: r_incb, degenerate: 1'b0};
        end else if (w_fs.dgn) begin
            w_res = '{angle_rad: '0, is_feature: 1'b0, degenerate: 1'b1};
        end else begin
            w_res.angle_rad  = (|w_ang[Z_W-1:ANG_W]) ? '1 : w_ang[ANG_W-1:0];
            w_res.is_feature = w_zq > Z_W'(w_thr_q30);
            w_res.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_fs.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_data <= w_res;
        end
    end

endmodule

>>> rtl/core/mdfe_checker.sv
`include "mesh_dihedral_feature_edge_core_macros.svh"

module mdfe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input mdfe_pkg::t_out_item            o_out_data
);
    import mdfe_pkg::*;

    // A result waiting at the output stays until it is taken.
    `MDFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // The pipeline freezes while the output is stalled, and flows when it is empty.
    `MDFE_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `MDFE_ASSERT_IMP(a_empty_flows, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // A degenerate edge never reports an angle or a feature.
    `MDFE_ASSERT_IMP(a_dgn_zero, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, o_out_data.angle_rad == '0 && !o_out_data.is_feature)

endmodule

bind mesh_dihedral_feature_edge_core mdfe_checker u_mdfe_checker (.*);

>>> bench/mesh_dihedral_feature_edge_core_tb.sv
module mesh_dihedral_feature_edge_core_tb;
    import mdfe_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int N_PHASES = 6;
    localparam int RANDOM_PER_PHASE = 305;
    localparam longint DEG_STEP = 18740331;
    localparam longint QUARTER_TURN = 1686629713;
    localparam longint ATAN_STEP [18] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_THRESHOLD;
    logic [THR_W-1:0] i_cfg_data = '0;

    mesh_dihedral_feature_edge_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Copy of the register file as the block should hold it.
    int unsigned thr_deg = 40;
    bit inc_boundary = 1'b0;

    t_in_item edge_queue[$];
    t_out_item angle_queue[$];
    int in_idle_max = 12;
    int out_idle_max = 12;
    bit hold_phase = 1'b0;
    int errors = 0;
    int n_checked = 0;
    int n_features = 0;
    int n_degenerate = 0;

    function automatic longint coord(logic [VTX_W-1:0] v, int k);
        logic signed [19:0] c;
        c = v[20*k +: 20];
        return longint'(c);
    endfunction

    function automatic void face_normal(logic [VTX_W-1:0] p0, logic [VTX_W-1:0] p1,
                                        logic [VTX_W-1:0] p2, output longint n[3]);
        longint a[3], b[3];
        for (int k = 0; k < 3; k++) begin
            a[k] = coord(p0, k) - coord(p1, k);
            b[k] = coord(p0, k) - coord(p2, k);
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Scales all components by one power of two so the largest lies in [2^14, 2^15).
    function automatic bit scale_normal(inout longint n[3]);
        longint unsigned mag[3];
        longint unsigned m, v;
        int len;
        m = 0;
        len = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = n[k] < 0 ? longint'(-n[k]) : n[k];
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) return 1'b0;
        while (len < 64 && (m >> len) != 0) len++;
        for (int k = 0; k < 3; k++) begin
            v = len > NORM_BITS ? mag[k] >> (len - NORM_BITS) : mag[k] << (NORM_BITS - len);
            n[k] = n[k] < 0 ? -longint'(v) : longint'(v);
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_out_item dihedral_angle(t_in_item e);
        t_out_item r;
        longint n1[3], n2[3], c[3];
        longint x, y, z, xs, ys, t;
        longint unsigned sq, zq, ang;
        r = '0;
        if (!e.has_second_face) begin
            r.is_feature = inc_boundary;
            return r;
        end
        face_normal(e.tri1_vertex_a, e.tri1_vertex_b, e.tri1_vertex_c, n1);
        face_normal(e.tri2_vertex_a, e.tri2_vertex_b, e.tri2_vertex_c, n2);
        if (!scale_normal(n1) || !scale_normal(n2)) begin
            r.degenerate = 1'b1;
            return r;
        end
        c[0] = n1[1] * n2[2] - n1[2] * n2[1];
        c[1] = n1[2] * n2[0] - n1[0] * n2[2];
        c[2] = n1[0] * n2[1] - n1[1] * n2[0];
        sq = 0;
        for (int k = 0; k < 3; k++) sq += longint'(c[k] * c[k]);
        x = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
        y = longint'(floor_sqrt(sq));
        z = 0;
        // An obtuse angle is turned by a quarter first so the CORDIC converges.
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = QUARTER_TURN;
        end
        for (int i = 0; i < 18; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += ATAN_STEP[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_STEP[i];
            end
        end
        zq = z < 0 ? 0 : z;
        ang = (zq + (64'd1 << 13)) >> 14;
        if (ang > 262143) ang = 262143;
        r.angle_rad = ang[ANG_W-1:0];
        r.is_feature = zq > longint'(thr_deg) * DEG_STEP;
        return r;
    endfunction

    function automatic logic [VTX_W-1:0] vtx(int x, int y, int z);
        return {z[19:0], y[19:0], x[19:0]};
    endfunction

    function automatic int rand_coord();
        return $signed($urandom) >>> $urandom_range(12, 31);
    endfunction

    function automatic logic [VTX_W-1:0] rand_vtx();
        return vtx(rand_coord(), rand_coord(), rand_coord());
    endfunction

    // Mostly two faces sharing an edge, as a mesh delivers them; the rest is noise
    // and the corner cases.
    function automatic t_in_item random_edge();
        t_in_item e;
        int pick;
        logic [VTX_W-1:0] a, b;
        logic [383:0] raw;
        pick = $urandom_range(0, 99);
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        a = rand_vtx();
        b = rand_vtx();
        e.tri1_vertex_a = a;
        e.tri1_vertex_b = b;
        e.tri1_vertex_c = rand_vtx();
        e.tri2_vertex_a = b;
        e.tri2_vertex_b = a;
        e.tri2_vertex_c = rand_vtx();
        e.has_second_face = 1'b1;
        if (pick < 10) begin
            e = raw[$bits(t_in_item)-1:0];
        end else if (pick < 20) begin
            e.has_second_face = 1'b0;
            e.tri2_vertex_c = raw[VTX_W-1:0];
        end else if (pick < 26) begin
            e.tri2_vertex_c = a;
        end else if (pick < 32) begin
            e.tri2_vertex_a = a;
            e.tri2_vertex_b = b;
            e.tri2_vertex_c = e.tri1_vertex_c;
        end else if (pick < 38) begin
            e.tri2_vertex_c = e.tri1_vertex_c;
        end
        return e;
    endfunction

    function automatic t_in_item make_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                           logic [VTX_W-1:0] c, logic [VTX_W-1:0] d,
                                           logic [VTX_W-1:0] e, logic [VTX_W-1:0] f,
                                           logic two);
        t_in_item r;
        r = {a, b, c, d, e, f, two};
        return r;
    endfunction

    task automatic enqueue_edge(t_in_item e);
        edge_queue = {edge_queue, e};
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_THRESHOLD) thr_deg = int'(value);
        else inc_boundary = value[0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender: predicts each edge at its transfer and offers the next after a random gap, which may be zero.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) angle_queue = {angle_queue, dihedral_angle(i_in_data)};
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (edge_queue.size() > 0) begin
                i_in_data <= edge_queue.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= int'($urandom_range(0, in_idle_max));
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer and stalls at random.
    int out_stall = 0;
    bit hold_taken = 1'b0;
    always @(posedge i_clk) begin
        t_out_item want;
        int pause;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (angle_queue.size() == 0) begin
                    errors++;
                    $display("result transfer with nothing expected");
                end else begin
                    want = angle_queue.pop_front();
                    if (o_out_data.angle_rad !== want.angle_rad)
                        report_mismatch("angle_rad", int'(o_out_data.angle_rad),
                                        int'(want.angle_rad));
                    if (o_out_data.is_feature !== want.is_feature)
                        report_mismatch("is_feature", int'(o_out_data.is_feature),
                                        int'(want.is_feature));
                    if (o_out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", int'(o_out_data.degenerate),
                                        int'(want.degenerate));
                    n_features += int'(want.is_feature);
                    n_degenerate += int'(want.degenerate);
                end
                n_checked++;
            end
            if (hold_phase && !hold_taken) begin
                hold_taken <= 1'b1;
                out_stall <= LONG_HOLD;
                i_out_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                // A pause of zero keeps the receiver ready for the next transfer.
                pause = int'($urandom_range(0, out_idle_max));
                out_stall <= (pause > 0) ? pause - 1 : 0;
                i_out_ready <= (pause == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [THR_W-1:0] thr_list[N_PHASES];
        logic [THR_W-1:0] inc_list[N_PHASES];
        logic [VTX_W-1:0] o, px, py, pz, mx, mn;
        thr_list = '{7'd40, 7'd0, 7'd90, 7'd127, 7'd1, 7'd45};
        inc_list = '{7'd0, 7'd1, 7'd0, 7'd1, 7'd0, 7'd1};
        o = vtx(0, 0, 0);
        px = vtx(1000, 0, 0);
        py = vtx(0, 1000, 0);
        pz = vtx(0, 0, 1000);
        mx = vtx(524287, 524287, 524287);
        mn = vtx(-524288, -524288, -524288);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_THRESHOLD, thr_list[ph]);
                write_reg(CFG_INC_BND, inc_list[ph]);
            end
            in_idle_max = (ph == 1) ? 0 : 12;
            out_idle_max = (ph == 1) ? 0 : 12;
            hold_phase = (ph == 2);
            // Boundary, degenerate, flat, folded, right-angle and extreme edges.
            enqueue_edge(make_edge(px, py, o, '0, '0, '0, 1'b0));
            enqueue_edge(make_edge('1, '1, '1, '1, '1, '1, 1'b0));
            enqueue_edge(make_edge(o, o, o, px, py, o, 1'b1));
            enqueue_edge(make_edge(px, py, o, o, px, vtx(2000, 0, 0), 1'b1));
            enqueue_edge(make_edge('1, '1, '1, '1, '1, '1, 1'b1));
            enqueue_edge(make_edge(o, px, py, px, o, vtx(0, -1000, 0), 1'b1));
            enqueue_edge(make_edge(o, px, py, px, o, py, 1'b1));
            enqueue_edge(make_edge(o, px, py, px, o, pz, 1'b1));
            enqueue_edge(make_edge(o, px, py, px, o, vtx(0, 1000, 1), 1'b1));
            enqueue_edge(make_edge(mx, mn, vtx(524287, -524288, 0),
                                   mn, mx, vtx(-524288, 524287, 0), 1'b1));
            enqueue_edge(make_edge(mn, vtx(524287, -524288, -524288),
                                   vtx(-524288, 524287, -524288), mn,
                                   vtx(-524288, 524287, -524288),
                                   vtx(-524288, -524288, 524287), 1'b1));
            enqueue_edge(make_edge(vtx(1, 0, 0), vtx(0, 1, 0), vtx(0, 0, 1),
                                   vtx(0, 1, 0), vtx(1, 0, 0), vtx(1, 1, 1), 1'b1));
            enqueue_edge(make_edge(o, px, py, px, o, vtx(500, -1, 0), 1'b1));
            for (int i = 0; i < RANDOM_PER_PHASE; i++) enqueue_edge(random_edge());
            while (edge_queue.size() > 0 || i_in_valid || angle_queue.size() > 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end

        $display("Checked %0d edges over %0d register settings: %0d features, %0d degenerate.",
                 n_checked, N_PHASES, n_features, n_degenerate);
        $display("Included one long output stall with a full pipeline and a phase with no idling.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
